// ===== sv/alf_pkg.sv =====
`timescale 1ns / 1ps
// Package for the array linked list with free list.
// Sizes, opcodes, FSM states and memory port structs; no dependencies.
package alf_pkg;

   localparam int ENTRIES     = 16;
   localparam int MAX_RESULTS = 16;
   localparam int IDX_W       = $clog2(ENTRIES + 1);
   localparam int ADDR_W      = $clog2(ENTRIES);
   localparam int READ_CAP    = (ENTRIES < MAX_RESULTS) ? ENTRIES : MAX_RESULTS;
   localparam int VAL_W       = 32;

   localparam logic [2:0] OP_SEARCH   = 3'd0;
   localparam logic [2:0] OP_INS_HEAD = 3'd1;
   localparam logic [2:0] OP_INS_TAIL = 3'd2;
   localparam logic [2:0] OP_INS_ORD  = 3'd3;
   localparam logic [2:0] OP_READ_OUT = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_FREE,
      S_WALK,
      S_FIN
   } state_type;

   typedef struct packed {
      logic              value_en;
      logic              link_en;
      logic [ADDR_W-1:0] addr;
      logic [VAL_W-1:0]  value;
      logic [IDX_W-1:0]  link;
   } mem_wr_type;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic [IDX_W-1:0] link;
   } mem_rd_type;

endpackage

// ===== sv/alf_mem.sv =====
`timescale 1ns / 1ps
// Record store: value and link memories, one write and one read port,
// registered read. Link entries read as index+1 until written. Uses alf_pkg.
module alf_mem
   import alf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   input  mem_wr_type        wr,
   output mem_rd_type        rd
);

   logic [VAL_W-1:0]  value_mem_ff [ENTRIES];
   logic [IDX_W-1:0]  link_mem_ff  [ENTRIES];
   logic [ENTRIES-1:0] link_vld_ff;

   logic [VAL_W-1:0]  rd_value_ff;
   logic [IDX_W-1:0]  rd_link_ff;
   logic [ADDR_W-1:0] rd_addr_ff;
   logic              rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr.value_en) begin
         value_mem_ff[wr.addr] <= wr.value;
      end
      if (wr.link_en) begin
         link_mem_ff[wr.addr] <= wr.link;
      end
      if (rd_en) begin
         rd_value_ff <= value_mem_ff[rd_addr];
         rd_link_ff  <= link_mem_ff[rd_addr];
         rd_addr_ff  <= rd_addr;
         rd_vld_ff   <= link_vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_vld_ff <= '0;
      end else if (wr.link_en) begin
         link_vld_ff[wr.addr] <= 1'b1;
      end
   end

   assign rd.value = rd_value_ff;
   assign rd.link  = rd_vld_ff ? rd_link_ff : (IDX_W'(rd_addr_ff) + IDX_W'(1));

endmodule

// ===== sv/array_linked_list_with_free_list_core.sv =====
`timescale 1ns / 1ps
// Array linked list with free list, top level. Uses alf_pkg and alf_mem.
// Search and read out walk the list from its head; head insert takes a record off the free
// list; tail and ordered insert also walk the list when it is not empty.
// A response stall holds the FSM in place. One link per cycle, set by the single-read-port
// record store, unless read out waits on the response side. Read out streams one result
// per record. Reset: value list empty, all records chained on the free list.
module array_linked_list_with_free_list_core
   import alf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [2:0]              req_opcode,
   input  logic signed [VAL_W-1:0] req_key_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_success,
   output logic                    rsp_item_valid,
   output logic signed [VAL_W-1:0] rsp_out_value,
   output logic                    rsp_last
);

   localparam logic [IDX_W-1:0] END_IDX = IDX_W'(ENTRIES);

   state_type state_ff, state_in;
   logic [2:0]              op_ff, op_in;
   logic signed [VAL_W-1:0] key_ff, key_in;
   logic [IDX_W-1:0]        list_head_ff, list_head_in;
   logic [IDX_W-1:0]        free_head_ff, free_head_in;
   logic [ADDR_W-1:0]       new_ff, new_in;
   logic [ADDR_W-1:0]       cur_ff, cur_in;
   logic [ADDR_W-1:0]       prev_ff, prev_in;
   logic                    prev_head_ff, prev_head_in;
   logic [IDX_W-1:0]        steps_ff, steps_in;
   logic [IDX_W-1:0]        link_new_ff, link_new_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_success_ff, rsp_success_in;
   logic                    rsp_item_valid_ff, rsp_item_valid_in;
   logic signed [VAL_W-1:0] rsp_out_value_ff, rsp_out_value_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   mem_wr_type        wr;
   mem_rd_type        rd;

   logic              out_free;
   logic              emit;
   logic              emit_ok;
   logic              emit_item;
   logic [VAL_W-1:0]  emit_val;
   logic              emit_last;
   logic              head_end;
   logic              free_end;
   logic              nxt_end;
   logic [IDX_W-1:0]  steps_inc;
   logic              walk_cap;
   logic              read_last;

   alf_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .wr      (wr),
      .rd      (rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         list_head_ff <= END_IDX;
         free_head_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         list_head_ff <= list_head_in;
         free_head_ff <= free_head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff             <= op_in;
      key_ff            <= key_in;
      new_ff            <= new_in;
      cur_ff            <= cur_in;
      prev_ff           <= prev_in;
      prev_head_ff      <= prev_head_in;
      steps_ff          <= steps_in;
      link_new_ff       <= link_new_in;
      rsp_success_ff    <= rsp_success_in;
      rsp_item_valid_ff <= rsp_item_valid_in;
      rsp_out_value_ff  <= rsp_out_value_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign head_end  = (list_head_ff >= END_IDX);
   assign free_end  = (free_head_ff >= END_IDX);
   assign nxt_end   = (rd.link >= END_IDX);
   assign steps_inc = steps_ff + IDX_W'(1);
   assign walk_cap  = (steps_inc >= END_IDX);
   assign read_last = nxt_end || walk_cap || (steps_inc >= IDX_W'(READ_CAP));

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      list_head_in = list_head_ff;
      free_head_in = free_head_ff;
      new_in       = new_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      prev_head_in = prev_head_ff;
      steps_in     = steps_ff;
      link_new_in  = link_new_ff;
      req_ready    = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = cur_ff;
      wr           = '0;
      emit         = 1'b0;
      emit_ok      = 1'b0;
      emit_item    = 1'b0;
      emit_val     = '0;
      emit_last    = 1'b1;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req_opcode;
               key_in   = req_key_value;
               state_in = S_START;
            end
         end
         S_START: begin
            case (op_ff)
               OP_SEARCH, OP_READ_OUT: begin
                  if (head_end) begin
                     emit = 1'b1;
                     if (out_free) begin
                        state_in = S_IDLE;
                     end
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = list_head_ff[ADDR_W-1:0];
                     cur_in   = list_head_ff[ADDR_W-1:0];
                     steps_in = '0;
                     state_in = S_WALK;
                  end
               end
               OP_INS_HEAD, OP_INS_TAIL, OP_INS_ORD: begin
                  if (free_end) begin
                     emit = 1'b1;
                     if (out_free) begin
                        state_in = S_IDLE;
                     end
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = free_head_ff[ADDR_W-1:0];
                     new_in   = free_head_ff[ADDR_W-1:0];
                     state_in = S_FREE;
                  end
               end
               default: begin
                  emit = 1'b1;
                  if (out_free) begin
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_FREE: begin
            free_head_in = rd.link;
            prev_head_in = 1'b1;
            if (op_ff == OP_INS_HEAD) begin
               list_head_in = IDX_W'(new_ff);
               link_new_in  = list_head_ff;
               state_in     = S_FIN;
            end else if (head_end) begin
               list_head_in = IDX_W'(new_ff);
               link_new_in  = END_IDX;
               state_in     = S_FIN;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = list_head_ff[ADDR_W-1:0];
               cur_in   = list_head_ff[ADDR_W-1:0];
               steps_in = '0;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            case (op_ff)
               OP_SEARCH: begin
                  if (rd.value == key_ff) begin
                     emit    = 1'b1;
                     emit_ok = 1'b1;
                     if (out_free) begin
                        state_in = S_IDLE;
                     end
                  end else if (nxt_end || walk_cap) begin
                     emit = 1'b1;
                     if (out_free) begin
                        state_in = S_IDLE;
                     end
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = rd.link[ADDR_W-1:0];
                     cur_in   = rd.link[ADDR_W-1:0];
                     steps_in = steps_inc;
                  end
               end
               OP_READ_OUT: begin
                  emit      = 1'b1;
                  emit_ok   = 1'b1;
                  emit_item = 1'b1;
                  emit_val  = rd.value;
                  emit_last = read_last;
                  if (out_free) begin
                     if (read_last) begin
                        state_in = S_IDLE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = rd.link[ADDR_W-1:0];
                        cur_in   = rd.link[ADDR_W-1:0];
                        steps_in = steps_inc;
                     end
                  end
               end
               OP_INS_TAIL, OP_INS_ORD: begin
                  if ((op_ff == OP_INS_ORD) && !($signed(rd.value) < key_ff)) begin
                     link_new_in = IDX_W'(cur_ff);
                     if (prev_head_ff) begin
                        list_head_in = IDX_W'(new_ff);
                     end else begin
                        wr.link_en = 1'b1;
                        wr.addr    = prev_ff;
                        wr.link    = IDX_W'(new_ff);
                     end
                     state_in = S_FIN;
                  end else if (nxt_end || walk_cap) begin
                     wr.link_en  = 1'b1;
                     wr.addr     = cur_ff;
                     wr.link     = IDX_W'(new_ff);
                     link_new_in = ((op_ff == OP_INS_ORD) && !nxt_end) ? rd.link : END_IDX;
                     state_in    = S_FIN;
                  end else begin
                     prev_head_in = 1'b0;
                     prev_in      = cur_ff;
                     rd_en        = 1'b1;
                     rd_addr      = rd.link[ADDR_W-1:0];
                     cur_in       = rd.link[ADDR_W-1:0];
                     steps_in     = steps_inc;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_FIN: begin
            wr.value_en = 1'b1;
            wr.link_en  = 1'b1;
            wr.addr     = new_ff;
            wr.value    = key_ff;
            wr.link     = link_new_ff;
            emit        = 1'b1;
            emit_ok     = 1'b1;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_success_in    = rsp_success_ff;
      rsp_item_valid_in = rsp_item_valid_ff;
      rsp_out_value_in  = rsp_out_value_ff;
      rsp_last_in       = rsp_last_ff;
      if (emit && out_free) begin
         rsp_valid_in      = 1'b1;
         rsp_success_in    = emit_ok;
         rsp_item_valid_in = emit_item;
         rsp_out_value_in  = emit_val;
         rsp_last_in       = emit_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_success    = rsp_success_ff;
   assign rsp_item_valid = rsp_item_valid_ff;
   assign rsp_out_value  = rsp_out_value_ff;
   assign rsp_last       = rsp_last_ff;

   a_heads_in_range: assert property (@(posedge clock) disable iff (reset)
      (list_head_ff <= END_IDX) && (free_head_ff <= END_IDX))
      else $error("list or free head beyond end marker");

   a_walk_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (steps_ff < END_IDX))
      else $error("walk exceeded record count");

   a_no_self_link: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |-> (link_new_ff != IDX_W'(new_ff)))
      else $error("new record links to itself");

endmodule

// ===== tb/alf_list_checker.sv =====
`timescale 1ns / 1ps
// Response checker for array_linked_list_with_free_list_core: tracks the record
// store, value list and free list, and compares each response in order. Uses alf_pkg.
module alf_list_checker
   import alf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [2:0]              req_opcode,
   input  logic signed [VAL_W-1:0] req_key_value,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic                    rsp_success,
   input  logic                    rsp_item_valid,
   input  logic signed [VAL_W-1:0] rsp_out_value,
   input  logic                    rsp_last,
   output int                      mismatch_count,
   output int                      owed_rsp_count
);

   typedef struct packed {
      logic             success;
      logic             item_valid;
      logic [VAL_W-1:0] out_value;
      logic             last;
   } list_rsp_type;

   list_rsp_type     owed_rsp_q[$];
   logic [VAL_W-1:0] rec_value [ENTRIES];
   int unsigned      rec_link [ENTRIES];
   int unsigned      list_first;
   int unsigned      free_first;
   int               errs = 0;

   task automatic clear_list();
      for (int i = 0; i < ENTRIES; i++) begin
         rec_value[i] = '0;
         rec_link[i]  = i + 1;
      end
      list_first = ENTRIES;
      free_first = 0;
   endtask

   task automatic owe_rsp(input logic ok, input logic iv, input logic [VAL_W-1:0] v,
                          input logic fin);
      list_rsp_type r;
      r.success    = ok;
      r.item_valid = iv;
      r.out_value  = v;
      r.last       = fin;
      owed_rsp_q.push_back(r);
   endtask

   task automatic apply_list_op(input logic [2:0] op, input logic [VAL_W-1:0] key);
      int unsigned pos;
      int unsigned prev;
      int unsigned rec;
      int unsigned steps;
      int unsigned count;
      logic        done;
      logic        fin;
      done = 1'b0;
      case (op)
         OP_SEARCH: begin
            pos = list_first;
            for (steps = 0; pos < ENTRIES && steps < ENTRIES && !done; steps++) begin
               if (rec_value[pos] == key) done = 1'b1;
               else pos = rec_link[pos];
            end
            owe_rsp(done, 1'b0, '0, 1'b1);
         end
         OP_INS_HEAD: begin
            if (free_first >= ENTRIES) begin
               owe_rsp(1'b0, 1'b0, '0, 1'b1);
            end else begin
               rec            = free_first;
               free_first     = rec_link[rec];
               rec_value[rec] = key;
               rec_link[rec]  = list_first;
               list_first     = rec;
               owe_rsp(1'b1, 1'b0, '0, 1'b1);
            end
         end
         OP_INS_TAIL, OP_INS_ORD: begin
            if (free_first >= ENTRIES) begin
               owe_rsp(1'b0, 1'b0, '0, 1'b1);
            end else begin
               rec        = free_first;
               free_first = rec_link[rec];
               // prev == ENTRIES means the new record becomes the list head
               prev = ENTRIES;
               pos  = list_first;
               for (steps = 0; pos < ENTRIES && steps < ENTRIES && !done; steps++) begin
                  if (op == OP_INS_ORD && !($signed(rec_value[pos]) < $signed(key))) begin
                     done = 1'b1;
                  end else begin
                     prev = pos;
                     pos  = rec_link[pos];
                  end
               end
               rec_value[rec] = key;
               rec_link[rec]  = (op == OP_INS_ORD && pos < ENTRIES) ? pos : ENTRIES;
               if (prev == ENTRIES) list_first = rec;
               else rec_link[prev] = rec;
               owe_rsp(1'b1, 1'b0, '0, 1'b1);
            end
         end
         OP_READ_OUT: begin
            count = 0;
            pos   = list_first;
            for (steps = 0; pos < ENTRIES && steps < ENTRIES && count < MAX_RESULTS;
                 steps++) begin
               fin = (rec_link[pos] >= ENTRIES) || (steps + 1 >= ENTRIES) ||
                     (count + 1 >= MAX_RESULTS);
               owe_rsp(1'b1, 1'b1, rec_value[pos], fin);
               count++;
               pos = rec_link[pos];
            end
            if (count == 0) owe_rsp(1'b0, 1'b0, '0, 1'b1);
         end
         default: begin
            owe_rsp(1'b0, 1'b0, '0, 1'b1);
         end
      endcase
   endtask

   task automatic note_mismatch(input string msg);
      if (errs < 10) $display("%0t: %s", $time, msg);
      errs++;
   endtask

   always @(posedge clock) begin
      list_rsp_type want;
      if (reset) begin
         clear_list();
         owed_rsp_q.delete();
      end else begin
         if (req_valid && req_ready) apply_list_op(req_opcode, req_key_value);
         if (rsp_valid && rsp_ready) begin
            if (owed_rsp_q.size() == 0) begin
               note_mismatch($sformatf("response with none owed: %b %b %h %b",
                  rsp_success, rsp_item_valid, rsp_out_value, rsp_last));
            end else begin
               want = owed_rsp_q.pop_front();
               if (rsp_success !== want.success)
                  note_mismatch($sformatf("success: expected %b, got %b",
                     want.success, rsp_success));
               if (rsp_item_valid !== want.item_valid)
                  note_mismatch($sformatf("item_valid: expected %b, got %b",
                     want.item_valid, rsp_item_valid));
               if (rsp_out_value !== want.out_value)
                  note_mismatch($sformatf("out_value: expected %h, got %h",
                     want.out_value, rsp_out_value));
               if (rsp_last !== want.last)
                  note_mismatch($sformatf("last: expected %b, got %b",
                     want.last, rsp_last));
            end
         end
      end
      owed_rsp_count <= owed_rsp_q.size();
      mismatch_count <= errs;
   end

endmodule

// ===== tb/array_linked_list_with_free_list_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for array_linked_list_with_free_list_core: clock, reset, request
// and response handshakes with idling and back-pressure. Uses alf_pkg, alf_list_checker.
module array_linked_list_with_free_list_core_tb;
   import alf_pkg::*;

   localparam int         CLK_PERIOD  = 8;
   localparam int         RAND_ITEMS  = 430;
   localparam int         HOLD_CYCLES = 400;
   localparam int         CYCLE_LIMIT = 1000000;
   localparam logic [2:0] OP_UNDEF_LO = 3'd5;
   localparam logic [2:0] OP_UNDEF_HI = 3'd7;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [2:0]              req_opcode;
   logic signed [VAL_W-1:0] req_key_value;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic                    rsp_success;
   logic                    rsp_item_valid;
   logic signed [VAL_W-1:0] rsp_out_value;
   logic                    rsp_last;
   int                      mismatch_count;
   int                      owed_rsp_count;

   int               send_idle_pct = 21;
   int               recv_idle_pct = 56;
   logic             hold_go = 1'b0;
   logic             hold_done = 1'b0;
   int               hold_count;
   int               cycle_count;
   logic [VAL_W-1:0] inserted_keys[$];

   always #(CLK_PERIOD / 2) clock = ~clock;

   array_linked_list_with_free_list_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_key_value  (req_key_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_success    (rsp_success),
      .rsp_item_valid (rsp_item_valid),
      .rsp_out_value  (rsp_out_value),
      .rsp_last       (rsp_last)
   );

   alf_list_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_key_value  (req_key_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_success    (rsp_success),
      .rsp_item_valid (rsp_item_valid),
      .rsp_out_value  (rsp_out_value),
      .rsp_last       (rsp_last),
      .mismatch_count (mismatch_count),
      .owed_rsp_count (owed_rsp_count)
   );

   task automatic send_req(input logic [2:0] op, input logic [VAL_W-1:0] key);
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_key_value <= key;
      if (op == OP_INS_HEAD || op == OP_INS_TAIL || op == OP_INS_ORD)
         inserted_keys.push_back(key);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
   endtask

   function automatic logic [2:0] pick_opcode();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 30) return OP_SEARCH;
      else if (roll < 40) return OP_INS_HEAD;
      else if (roll < 50) return OP_INS_TAIL;
      else if (roll < 62) return OP_INS_ORD;
      else if (roll < 92) return OP_READ_OUT;
      else return 3'($urandom_range(OP_UNDEF_HI, OP_UNDEF_LO));
   endfunction

   function automatic logic [VAL_W-1:0] pick_key();
      case ($urandom_range(4))
         0: return $urandom();
         1: return $urandom_range(7) << 16;
         2: begin
            if (inserted_keys.size() == 0) return $urandom();
            return inserted_keys[$urandom_range(inserted_keys.size() - 1)];
         end
         3: begin
            case ($urandom_range(3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h0000_0000;
               default: return 32'hffff_ffff;
            endcase
         end
         default: return -($urandom_range(7) << 16);
      endcase
   endfunction

   // response side back-pressure, with one long hold-off
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !hold_done) begin
            rsp_ready <= 1'b0;
            hold_done = 1'b1;
            for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_opcode    <= OP_SEARCH;
      req_key_value <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty list, undefined opcodes, extremes, unsorted and equal ordered inserts
      send_req(OP_READ_OUT, 32'h0000_0000);
      send_req(OP_SEARCH, 32'h0000_0000);
      send_req(OP_UNDEF_LO, 32'h7fff_ffff);
      send_req(OP_UNDEF_LO + 3'd1, 32'h8000_0000);
      send_req(OP_UNDEF_HI, 32'hffff_ffff);
      send_req(OP_INS_ORD, 32'h7fff_ffff);
      send_req(OP_INS_ORD, 32'h8000_0000);
      send_req(OP_INS_TAIL, 32'h0000_0000);
      send_req(OP_INS_ORD, 32'h0005_0000);
      send_req(OP_INS_ORD, 32'h0005_0000);
      send_req(OP_INS_HEAD, 32'hffff_ffff);
      send_req(OP_SEARCH, 32'h0005_0000);
      send_req(OP_SEARCH, 32'h7fff_ffff);
      send_req(OP_SEARCH, 32'h8000_0000);
      send_req(OP_SEARCH, 32'h0000_0001);
      send_req(OP_READ_OUT, 32'hffff_ffff);
      send_req(OP_INS_TAIL, 32'h0000_8000);
      send_req(OP_READ_OUT, 32'h0000_0000);

      hold_go = 1'b1;
      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n == RAND_ITEMS / 3) begin
            send_idle_pct = 56;
            recv_idle_pct = 21;
         end else if (n == 2 * RAND_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         send_req(pick_opcode(), pick_key());
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (owed_rsp_count != 0) @(posedge clock);
      repeat (2 * ENTRIES + 8) @(posedge clock);
      if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
